>>> sv/st3eq_pkg.sv
// Package: shared types and constants for the stereo three-band equalizer.
package st3eq_pkg;
    localparam int NUM_STAGES = 3;
    localparam int COEF_FRAC  = 16;
    localparam logic [16:0] MIX_ONE    = 17'd65536;
    localparam logic [16:0] BYPASS_MIX = 17'd6;

    localparam logic [2:0] REG_LOW_FF  = 3'd0;
    localparam logic [2:0] REG_LOW_FB  = 3'd1;
    localparam logic [2:0] REG_MID_FF  = 3'd2;
    localparam logic [2:0] REG_MID_FB  = 3'd3;
    localparam logic [2:0] REG_HIGH_FF = 3'd4;
    localparam logic [2:0] REG_HIGH_FB = 3'd5;
    localparam logic [2:0] REG_GAIN    = 3'd6;
    localparam logic [2:0] REG_MIX     = 3'd7;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_MAC,
        ST_GAIN,
        ST_MIX,
        ST_OUT
    } state_t;
endpackage

>>> sv/st3eq_mac.sv
// Multiply-accumulate unit with registered product.
module st3eq_mac import st3eq_pkg::*; #(
    parameter int AW = 34,
    parameter int BW = 20,
    parameter int ACCW = 64
) (
    input  logic                   aclk,
    input  logic                   clr,
    input  logic                   en,
    input  logic                   neg,
    input  logic signed [AW-1:0]   a,
    input  logic signed [BW-1:0]   b,
    output logic signed [ACCW-1:0] acc
);
    logic signed [AW+BW-1:0] prod_reg;
    logic                    prod_v_reg;
    logic                    neg_reg;
    logic signed [ACCW-1:0]  acc_reg;

    always_ff @(posedge aclk) begin
        prod_reg   <= a * b;
        neg_reg    <= neg;
        prod_v_reg <= en;
        if (clr) begin
            acc_reg <= '0;
        end else if (prod_v_reg) begin
            if (neg_reg) acc_reg <= acc_reg - ACCW'(prod_reg);
            else         acc_reg <= acc_reg + ACCW'(prod_reg);
        end
    end
    assign acc = acc_reg;
endmodule

>>> sv/stereo_three_band_biquad_eq.sv
// Top level: stereo three-band biquad equalizer with gain and dry/wet blend.
// Sequence: a bypass item goes straight to the output registers; a filtered item runs each
// channel in turn through the biquad stages, gain and blend on one shared MAC, each biquad
// reading four history taps, forming five products, draining the MAC and writing back the taps.
// Flow: one item at a time; the next item is taken the cycle after the result leaves.
// Reset: synchronous active-low aresetn restores register defaults; a sweep then clears all
// 4*3*NUM_CHANNELS words of the history memory, and no item is taken meanwhile.
module stereo_three_band_biquad_eq import st3eq_pkg::*; #(
    parameter int SAMPLE_BITS  = 24,
    parameter int COEF_BITS    = 20,
    parameter int NUM_CHANNELS = 2
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [2:0]                    cfg_index,
    input  logic [59:0]                   cfg_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [SAMPLE_BITS-1:0] s_left_sample,
    input  logic signed [SAMPLE_BITS-1:0] s_right_sample,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [SAMPLE_BITS-1:0] m_left_out,
    output logic signed [SAMPLE_BITS-1:0] m_right_out
);
    localparam int SW    = SAMPLE_BITS;
    localparam int DEPTH = 4 * NUM_STAGES * NUM_CHANNELS;
    localparam int AW    = $clog2(DEPTH);
    localparam int OPW   = SW;          // operand: sample
    // coefficient / gain / mix operand, signed with room for unsigned gain
    localparam int CW    = ((COEF_BITS > 20) ? COEF_BITS : 20) + 1;
    localparam int ACCW  = 64;
    localparam logic signed [ACCW-1:0] SAT_HI = ACCW'((64'sd1 <<< (SW-1)) - 1);
    localparam logic signed [ACCW-1:0] SAT_LO = -SAT_HI - 1;

    // Configuration registers.
    logic [59:0] ff_reg [NUM_STAGES];
    logic [39:0] fb_reg [NUM_STAGES];
    logic [19:0] gain_reg;
    logic [16:0] mix_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_STAGES; i++) begin
                ff_reg[i] <= 60'd65536;
                fb_reg[i] <= '0;
            end
            gain_reg <= 20'd65536;
            mix_reg  <= MIX_ONE;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_LOW_FF:  ff_reg[0] <= cfg_data;
                REG_LOW_FB:  fb_reg[0] <= cfg_data[39:0];
                REG_MID_FF:  ff_reg[1] <= cfg_data;
                REG_MID_FB:  fb_reg[1] <= cfg_data[39:0];
                REG_HIGH_FF: ff_reg[2] <= cfg_data;
                REG_HIGH_FB: fb_reg[2] <= cfg_data[39:0];
                REG_GAIN:    gain_reg  <= cfg_data[19:0];
                REG_MIX:     mix_reg   <= cfg_data[16:0];
                default: ;
            endcase
        end
    end

    // Clamp the mix to full wet.
    logic [16:0] mix_eff;
    assign mix_eff = (mix_reg > MIX_ONE) ? MIX_ONE : mix_reg;

    // History memory: address = ch*4*NUM_STAGES + stage*4 + tap; tap 0=x1 1=x2 2=y1 3=y2.
    logic [SW-1:0] hist_mem [DEPTH];
    logic [SW-1:0] hist_rd_reg;
    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [SW-1:0] wdata;

    always_ff @(posedge aclk) begin
        if (we) hist_mem[waddr] <= wdata;
        hist_rd_reg <= hist_mem[raddr];
    end

    // Sequencer registers.
    state_t state_reg, state_next;
    logic [AW:0]   clr_reg;
    logic          clr_busy;
    logic          ch_reg;
    logic [1:0]    stg_reg;
    logic [3:0]    step_reg;
    logic signed [SW-1:0] x_reg;       // current stage input
    logic signed [SW-1:0] h_reg [4];   // history of current stage
    logic signed [SW-1:0] dry_reg [2];
    logic signed [SW-1:0] res_reg [2];
    logic          bypass_reg;
    logic          ovalid_reg;

    assign clr_busy = (clr_reg != (AW+1)'(DEPTH));

    // MAC operand selection.
    logic                   mac_clr, mac_en, mac_neg;
    logic signed [OPW-1:0]  mac_a;
    logic signed [CW-1:0]   mac_b;
    logic signed [ACCW-1:0] acc;

    st3eq_mac #(.AW(OPW), .BW(CW), .ACCW(ACCW)) u_mac (
        .aclk(aclk), .clr(mac_clr), .en(mac_en), .neg(mac_neg),
        .a(mac_a), .b(mac_b), .acc(acc)
    );

    function automatic logic signed [ACCW-1:0] rnd_sat(input logic signed [ACCW-1:0] v);
        logic signed [ACCW-1:0] r;
        r = (v + ACCW'(64'sd1 <<< (COEF_FRAC-1))) >>> COEF_FRAC;
        if (r > SAT_HI) return SAT_HI;
        if (r < SAT_LO) return SAT_LO;
        return r;
    endfunction

    // Pick one 20-bit slot of a packed register and sign-extend COEF_BITS of it.
    function automatic logic signed [CW-1:0] coef_at(input logic [59:0] r, input int slot);
        logic [83:0] w;
        w = {24'd0, r} >> (20 * slot);
        return CW'($signed(w[COEF_BITS-1:0]));
    endfunction

    logic signed [ACCW-1:0] acc_rs;
    assign acc_rs = rnd_sat(acc);

    logic [AW-1:0] base;
    assign base = AW'((ch_reg * 4 * NUM_STAGES) + stg_reg * 4);

    // Step plan within ST_MAC per stage:
    // 0..3 issue reads of taps 0..3; 1..4 load h_reg; 5..9 issue products;
    // 10,11 drain MAC; 12..15 write back taps 0..3; advance at 15.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (s_valid && s_ready)
                         state_next = (mix_reg > BYPASS_MIX) ? ST_MAC : ST_OUT;
            ST_MAC:  if (step_reg == 4'd15 && stg_reg == 2'(NUM_STAGES-1))
                         state_next = ST_GAIN;
            ST_GAIN: if (step_reg == 4'd3) state_next = ST_MIX;
            ST_MIX:  if (step_reg == 4'd4)
                         state_next = (ch_reg == 1'(NUM_CHANNELS-1)) ? ST_OUT : ST_MAC;
            ST_OUT:  state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        raddr   = base + AW'(step_reg[1:0]);
        mac_clr = 1'b0;
        mac_en  = 1'b0;
        mac_neg = 1'b0;
        mac_a   = '0;
        mac_b   = '0;
        we      = 1'b0;
        waddr   = base;
        wdata   = '0;
        if (clr_busy) begin
            we    = 1'b1;
            waddr = clr_reg[AW-1:0];
        end
        case (state_reg)
            ST_MAC: begin
                if (step_reg == 4'd0) mac_clr = 1'b1;
                if (step_reg >= 4'd5 && step_reg <= 4'd9) begin
                    mac_en = 1'b1;
                    case (step_reg)
                        4'd5: begin mac_a = OPW'(x_reg);    mac_b = coef_at(ff_reg[stg_reg], 0); end
                        4'd6: begin mac_a = OPW'(h_reg[0]); mac_b = coef_at(ff_reg[stg_reg], 1); end
                        4'd7: begin mac_a = OPW'(h_reg[1]); mac_b = coef_at(ff_reg[stg_reg], 2); end
                        4'd8: begin mac_a = OPW'(h_reg[2]);
                                    mac_b = coef_at({20'd0, fb_reg[stg_reg]}, 0);
                                    mac_neg = 1'b1; end
                        default: begin mac_a = OPW'(h_reg[3]);
                                    mac_b = coef_at({20'd0, fb_reg[stg_reg]}, 1);
                                    mac_neg = 1'b1; end
                    endcase
                end
                if (step_reg >= 4'd12) begin
                    we = 1'b1;
                    waddr = base + AW'(step_reg[1:0]);
                    case (step_reg[1:0])
                        2'd0: wdata = x_reg;
                        2'd1: wdata = h_reg[0];
                        2'd2: wdata = SW'(acc_rs);
                        default: wdata = h_reg[2];
                    endcase
                end
            end
            ST_GAIN: begin
                if (step_reg == 4'd0) begin
                    mac_clr = 1'b1;
                end
                if (step_reg == 4'd1) begin
                    mac_en = 1'b1;
                    mac_a  = OPW'(x_reg);
                    mac_b  = CW'($signed({1'b0, gain_reg}));
                end
            end
            ST_MIX: begin
                if (step_reg == 4'd0) mac_clr = 1'b1;
                if (step_reg == 4'd1) begin
                    mac_en = 1'b1;
                    mac_a  = OPW'(dry_reg[ch_reg]);
                    mac_b  = CW'($signed({1'b0, MIX_ONE - mix_eff}));
                end
                if (step_reg == 4'd2) begin
                    mac_en = 1'b1;
                    mac_a  = OPW'(x_reg);
                    mac_b  = CW'($signed({1'b0, mix_eff}));
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            clr_reg    <= '0;
            ch_reg     <= 1'b0;
            stg_reg    <= '0;
            step_reg   <= '0;
            ovalid_reg <= 1'b0;
            bypass_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (clr_busy) clr_reg <= clr_reg + 1'b1;
            // Raise valid as the result is loaded; drop it once taken.
            if (state_reg == ST_OUT) ovalid_reg <= 1'b1;
            else if (m_ready) ovalid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE: begin
                    step_reg <= '0;
                    stg_reg  <= '0;
                    ch_reg   <= 1'b0;
                    if (s_valid && s_ready) begin
                        dry_reg[0] <= s_left_sample;
                        dry_reg[1] <= s_right_sample;
                        x_reg      <= s_left_sample;
                        bypass_reg <= (mix_reg <= BYPASS_MIX);
                    end
                end
                ST_MAC: begin
                    if (step_reg >= 4'd1 && step_reg <= 4'd4)
                        h_reg[step_reg[1:0] - 2'd1] <= hist_rd_reg;
                    if (step_reg == 4'd15) begin
                        x_reg    <= SW'(acc_rs);
                        step_reg <= '0;
                        stg_reg  <= (stg_reg == 2'(NUM_STAGES-1)) ? 2'd0 : stg_reg + 2'd1;
                    end else begin
                        step_reg <= step_reg + 4'd1;
                    end
                end
                ST_GAIN: begin
                    if (step_reg == 4'd3) begin
                        x_reg    <= SW'(acc_rs);
                        step_reg <= '0;
                    end else step_reg <= step_reg + 4'd1;
                end
                ST_MIX: begin
                    if (step_reg == 4'd4) begin
                        res_reg[ch_reg] <= SW'(acc_rs);
                        step_reg <= '0;
                        ch_reg   <= 1'b1;
                        x_reg    <= dry_reg[1];
                    end else step_reg <= step_reg + 4'd1;
                end
                ST_OUT: begin
                    // No result waits here: input is only taken with valid low.
                    if (bypass_reg) begin
                        m_left_out  <= dry_reg[0];
                        m_right_out <= (NUM_CHANNELS > 1) ? dry_reg[1] : dry_reg[0];
                    end else begin
                        m_left_out  <= res_reg[0];
                        m_right_out <= (NUM_CHANNELS > 1) ? res_reg[1] : res_reg[0];
                    end
                end
                default: ;
            endcase
        end
    end

    // Take a new item only when idle, the sweep is done and no result waits.
    assign s_ready = (state_reg == ST_IDLE) && !clr_busy && !ovalid_reg;
    assign m_valid = ovalid_reg;

    a_no_accept_in_sweep: assert property (@(posedge aclk) disable iff (!aresetn)
        clr_busy |-> !s_ready) else $error("item accepted during history sweep");
    a_ready_when_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MAC) |-> !s_ready) else $error("ready while filtering");
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_left_out)))
        else $error("result changed while stalled");
endmodule
